// ----- design/random_permutation_matrix_rows_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef RANDOM_PERMUTATION_MATRIX_ROWS_CORE_DEFINES_SVH
`define RANDOM_PERMUTATION_MATRIX_ROWS_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define RPM_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Next-cycle implication checked outside reset.
`define RPM_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/rpm_pkg.sv -----
// Shared constants and types for the permutation row generator.
package rpm_pkg;

	localparam int MAX_DIM = 64;
	localparam int COL_W   = 6;
	localparam int CNT_W   = 7;
	localparam int RND_W   = 31;
	localparam int ROW_W   = 64;
	localparam int STEP_W  = 5;
	localparam int GRP     = 8;

	typedef struct packed {
		logic             refill;
		logic             shift;
		logic [CNT_W-1:0] pos;
	} rpm_cell_ctrl_t;

endpackage

// ----- design/rpm_cell.sv -----
// One list cell: holds a column number, takes its upper neighbor's value on a removal.
module rpm_cell import rpm_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rpm_cell_ctrl_t       ctrl,
	input  logic [COL_W-1:0]     next_val,
	output logic [COL_W-1:0]     val,
	output logic [COL_W-1:0]     pick
);

	localparam logic [COL_W-1:0] OWN_COL = COL_W'(IDX);
	localparam logic [CNT_W-1:0] OWN_POS = CNT_W'(IDX);

	logic [COL_W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= OWN_COL;
		end else if (ctrl.refill) begin
			val_q <= OWN_COL;
		end else if (ctrl.shift && (OWN_POS >= ctrl.pos)) begin
			val_q <= next_val;
		end
	end

	assign val  = val_q;
	assign pick = (ctrl.pos == OWN_POS) ? val_q : '0;

endmodule

// ----- design/rpm_mod.sv -----
// Bit-serial remainder of the random word by the remaining count, one bit per cycle.
module rpm_mod import rpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             last_step,
	output logic [CNT_W-1:0] rem
);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [RND_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic [CNT_W-1:0]  rem_d;

	always_comb begin
		trial = {rem_q, quo_q[RND_W-1]};
		diff  = trial - {1'b0, divisor};
		rem_d = (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(RND_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[RND_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign last_step = busy_q && (cnt_q == '0);
	assign rem       = rem_q;

endmodule

// ----- design/random_permutation_matrix_rows_core.sv -----
// A result is registered after the bit-serial remainder (31 remainder bits), the cell shift
// and group select in ST_SEL, and the final select in ST_FIN, which waits for the output register.
// A new input is taken only in ST_IDLE, once the previous result has been registered.
// Output register lets the next input transfer while a result waits.
// Reset (async, active low): size 64, list holds 0..63, row 0, no result pending.
module random_permutation_matrix_rows_core import rpm_pkg::*; #(
	parameter int MAX_DIMENSION = MAX_DIM
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [RND_W-1:0] random_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [COL_W-1:0] chosen_column,
	output logic [ROW_W-1:0] row_bits,
	output logic [COL_W-1:0] row_index,
	output logic             last_row
);

	localparam int NGRP = (MAX_DIMENSION + GRP - 1) / GRP;
	localparam logic [CNT_W-1:0] SIZE_HI = CNT_W'(MAX_DIMENSION);
	localparam logic [CNT_W-1:0] SIZE_LO = CNT_W'(2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] size_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] size_d;
	logic [CNT_W-1:0] row_d;
	logic [COL_W-1:0] grp_q [NGRP];
	logic [COL_W-1:0] grp_d [NGRP];
	logic [COL_W-1:0] col_d;
	logic [COL_W-1:0] vals  [MAX_DIMENSION];
	logic [COL_W-1:0] picks [MAX_DIMENSION];
	logic             accept;
	logic             fin_fire;
	logic             is_last;
	logic             div_last;
	logic [CNT_W-1:0] pos;
	rpm_cell_ctrl_t   ctrl;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fin_fire = (state_q == ST_FIN) && (!out_valid || out_ready);
	assign is_last  = (count_q == CNT_W'(1));
	assign row_d    = size_q - count_q;

	always_comb begin
		if (cfg_data < SIZE_LO) begin
			size_d = SIZE_LO;
		end else if (cfg_data > SIZE_HI) begin
			size_d = SIZE_HI;
		end else begin
			size_d = cfg_data;
		end
	end

	always_comb begin
		ctrl.refill = cfg_we || (fin_fire && is_last);
		ctrl.shift  = (state_q == ST_SEL);
		ctrl.pos    = pos;
	end

	rpm_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (random_value),
		.divisor   (count_q),
		.last_step (div_last),
		.rem       (pos)
	);

	for (genvar i = 0; i < MAX_DIMENSION; i++) begin : g_cell
		logic [COL_W-1:0] nxt;
		if (i == MAX_DIMENSION - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = vals[i+1];
		end
		rpm_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.next_val (nxt),
			.val      (vals[i]),
			.pick     (picks[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < MAX_DIMENSION) begin
					grp_d[g] = grp_d[g] | picks[g * GRP + k];
				end
			end
		end
	end

	always_comb begin
		col_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			col_d = col_d | grp_q[g];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEL) begin
			grp_q <= grp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= SIZE_HI;
			count_q <= SIZE_HI;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
						count_q <= is_last ? size_q : count_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				size_q  <= size_d;
				count_q <= size_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fin_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			chosen_column <= col_d;
			row_bits      <= ROW_W'(1) << col_d;
			row_index     <= row_d[COL_W-1:0];
			last_row      <= is_last;
		end
	end

endmodule

// ----- design/rpm_checker.sv -----
// Port-level checks for the permutation row generator, bound to the top level.
`include "random_permutation_matrix_rows_core_defines.svh"

module rpm_checker import rpm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [COL_W-1:0] chosen_column,
	input logic [ROW_W-1:0] row_bits,
	input logic [COL_W-1:0] row_index,
	input logic             last_row
);

	`RPM_ASSERT(a_row_onehot, clk, arst_n, out_valid |-> (row_bits == (ROW_W'(1) << chosen_column)), "row bits do not match column")
	`RPM_ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while busy")
	`RPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(chosen_column) && $stable(row_index) && $stable(last_row), "stalled result changed")
	`RPM_ASSERT_NEXT(a_first_row, clk, arst_n, out_valid && out_ready && last_row, !out_valid || (row_index == '0) || !$rose(out_valid), "row numbering not restarted")

endmodule

bind random_permutation_matrix_rows_core rpm_checker u_rpm_checker (.*);

// ----- tb/tb.sv -----
// Testbench for random_permutation_matrix_rows_core: directed rows, then random matrices.
module tb;
	import rpm_pkg::*;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] bits;
		logic [COL_W-1:0] idx;
		logic             last;
	} perm_row_t;

	typedef struct packed {
		bit             size_wr;
		bit [CNT_W-1:0] size_val;
		bit [RND_W-1:0] word;
		bit             known;
		bit [COL_W-1:0] col;
		bit [COL_W-1:0] idx;
		bit             last;
	} dir_row_t;

	localparam int DIR_N = 16;
	localparam int RAND_ITEMS = 1700;
	localparam int HOLD_CYCLES = 300;

	// size writes of 0, 1, 65 and 127 saturate
	localparam dir_row_t DIR_TAB[DIR_N] = '{
		'{1'b0, 7'd0,   31'd0,          1'b1, 6'd0,  6'd0, 1'b0},
		'{1'b0, 7'd0,   31'h7fffffff,   1'b1, 6'd2,  6'd1, 1'b0},
		'{1'b1, 7'd0,   31'd1,          1'b1, 6'd1,  6'd0, 1'b0},
		'{1'b0, 7'd0,   31'd0,          1'b1, 6'd0,  6'd1, 1'b1},
		'{1'b0, 7'd0,   31'h7fffffff,   1'b1, 6'd1,  6'd0, 1'b0},
		'{1'b1, 7'd1,   31'h7fffffff,   1'b1, 6'd1,  6'd0, 1'b0},
		'{1'b0, 7'd0,   31'h7fffffff,   1'b1, 6'd0,  6'd1, 1'b1},
		'{1'b1, 7'd127, 31'd63,         1'b1, 6'd63, 6'd0, 1'b0},
		'{1'b0, 7'd0,   31'd63,         1'b0, 6'd0,  6'd0, 1'b0},
		'{1'b1, 7'd65,  31'h2aaaaaaa,   1'b0, 6'd0,  6'd0, 1'b0},
		'{1'b0, 7'd0,   31'h55555555,   1'b0, 6'd0,  6'd0, 1'b0},
		'{1'b1, 7'd3,   31'd5,          1'b1, 6'd2,  6'd0, 1'b0},
		'{1'b0, 7'd0,   31'd4,          1'b0, 6'd0,  6'd0, 1'b0},
		'{1'b0, 7'd0,   31'd0,          1'b1, 6'd1,  6'd2, 1'b1},
		'{1'b0, 7'd0,   31'd7,          1'b0, 6'd0,  6'd0, 1'b0},
		'{1'b1, 7'd64,  31'h40000000,   1'b0, 6'd0,  6'd0, 1'b0}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [RND_W-1:0] random_value;
	logic             out_valid;
	logic             out_ready;
	logic [COL_W-1:0] chosen_column;
	logic [ROW_W-1:0] row_bits;
	logic [COL_W-1:0] row_index;
	logic             last_row;

	random_permutation_matrix_rows_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chosen_column(chosen_column),
		.row_bits     (row_bits),
		.row_index    (row_index),
		.last_row     (last_row)
	);

	// model state: columns still free in the current matrix
	logic [COL_W-1:0] free_cols[MAX_DIM];
	int unsigned      cols_left;
	int unsigned      mat_size;

	perm_row_t pending_rows[$];
	int        mismatches;
	int        send_idle_pct;
	int        recv_idle_pct;
	bit        hold_req;
	int        hold_left;
	bit        known_row;
	perm_row_t known_val;

	function automatic void refill_cols();
		for (int i = 0; i < MAX_DIM; i++) begin
			free_cols[i] = (i < mat_size) ? COL_W'(i) : '0;
		end
		cols_left = mat_size;
	endfunction

	function automatic void load_size(input logic [CNT_W-1:0] v);
		if (v < 2) begin
			mat_size = 2;
		end else if (v > MAX_DIM) begin
			mat_size = MAX_DIM;
		end else begin
			mat_size = 32'(v);
		end
		refill_cols();
	endfunction

	function automatic perm_row_t make_row(input logic [COL_W-1:0] col,
			input logic [COL_W-1:0] idx, input logic last);
		perm_row_t r;
		r.col  = col;
		r.bits = ROW_W'(1) << col;
		r.idx  = idx;
		r.last = last;
		return r;
	endfunction

	function automatic perm_row_t draw_column(input logic [RND_W-1:0] word);
		int unsigned pos;
		logic [COL_W-1:0] col;
		int unsigned row;
		perm_row_t r;
		if (cols_left == 0 || cols_left > mat_size) begin
			refill_cols();
		end
		pos = word % cols_left;
		col = free_cols[pos];
		for (int unsigned i = pos; i + 1 < cols_left; i++) begin
			free_cols[i] = free_cols[i + 1];
		end
		row = mat_size - cols_left;
		cols_left--;
		r = make_row(col, COL_W'(row), cols_left == 0);
		if (cols_left == 0) begin
			refill_cols();
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#6000000;
		$display("** random_permutation_matrix_rows_core: FAILED **");
		$finish;
	end

	// output check first, then prediction of the input transfer
	always @(posedge clk) begin
		perm_row_t got;
		perm_row_t want;
		perm_row_t pred;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{chosen_column, row_bits, row_index, last_row};
				if (pending_rows.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected row: col %0d row %0d last %0d",
							got.col, got.idx, got.last);
					end
				end else begin
					want = pending_rows.pop_front();
					if (got.col !== want.col || got.bits !== want.bits ||
							got.idx !== want.idx || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp col %0d bits %h row %0d last %0d",
								want.col, want.bits, want.idx, want.last);
							$display("          got col %0d bits %h row %0d last %0d",
								got.col, got.bits, got.idx, got.last);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				pred = draw_column(random_value);
				pending_rows = {pending_rows, (known_row ? known_val : pred)};
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
					@(negedge clk);
				end
			end
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_word(input logic [RND_W-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			random_value = RND_W'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		random_value = word;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
		known_row = 1'b0;
	endtask

	task automatic write_size(input logic [CNT_W-1:0] v);
		while (pending_rows.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = CNT_W'($urandom);
		load_size(v);
	endtask

	function automatic logic [RND_W-1:0] pick_word();
		int sel;
		sel = $urandom_range(15);
		if (sel == 0) begin
			return '1;
		end else if (sel < 3) begin
			return RND_W'($urandom_range(200));
		end
		return RND_W'($urandom);
	endfunction

	function automatic logic [CNT_W-1:0] pick_size();
		case ($urandom_range(9))
			0: return CNT_W'(0);
			1: return CNT_W'(1);
			2: return CNT_W'(127);
			3: return CNT_W'(64);
			4: return CNT_W'($urandom_range(127));
			default: return CNT_W'($urandom_range(2, 64));
		endcase
	endfunction

	initial begin
		int sent;
		int chunk;
		int eff;
		logic [CNT_W-1:0] sz;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		random_value = '0;
		mismatches = 0;
		hold_req = 1'b0;
		known_row = 1'b0;
		known_val = '0;
		send_idle_pct = 28;
		recv_idle_pct = 49;
		load_size(CNT_W'(64));
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].size_wr) begin
				write_size(DIR_TAB[i].size_val);
			end
			known_row = DIR_TAB[i].known;
			known_val = make_row(DIR_TAB[i].col, DIR_TAB[i].idx, DIR_TAB[i].last);
			send_word(DIR_TAB[i].word);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 49;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < RAND_ITEMS / 3) begin
				sz = pick_size();
				write_size(sz);
				eff = mat_size;
				// whole matrices plus a partial one
				chunk = $urandom_range(1, 3) * eff + $urandom_range(0, eff - 1);
				if (chunk > RAND_ITEMS / 3 - sent) begin
					chunk = RAND_ITEMS / 3 - sent;
				end
				if (phase == 2 && sent == 0) begin
					hold_req = 1'b1;
				end
				for (int k = 0; k < chunk; k++) begin
					send_word(pick_word());
				end
				sent += chunk;
			end
		end

		while (pending_rows.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_rows.size() == 0) begin
			$display("** random_permutation_matrix_rows_core: PASSED **");
		end else begin
			$display("** random_permutation_matrix_rows_core: FAILED **");
		end
		$finish;
	end

endmodule
